[rtl/core/vn_pkg.sv]
// ============================================================================
// vn_pkg: shared types for the vector normalization core
// Holds the lane count and a control struct with valid and four_wide flags.
// ============================================================================
package vn_pkg;

    localparam int LANES = 4;

    typedef struct packed {
        logic valid;
        logic four_wide;
    } t_ctl;

endpackage

[rtl/core/vn_lane.sv]
// ============================================================================
// vn_lane: one component lane
// Registers the magnitude and the square of one component, then divides the
// scaled magnitude by the shared length with a pipelined restoring divider.
// ============================================================================
module vn_lane
    import vn_pkg::*;
#(
    parameter int COMP_WIDTH     = 16,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_en_in,
    input  logic signed [COMP_WIDTH-1:0]     i_comp,
    input  logic                             i_use,
    output logic [2*COMP_WIDTH-1:0]          o_square,
    input  logic [COMP_WIDTH:0]              i_len,
    input  logic                             i_div_en,
    output logic signed [UNIT_FRAC_BITS+1:0] o_unit
);

    localparam int MW = COMP_WIDTH + 1;
    localparam int NW = MW + UNIT_FRAC_BITS + 1;
    localparam int DW = MW + 1;
    localparam int QW = UNIT_FRAC_BITS + 2;
    localparam int MD = MW + 3;

    logic [MW-1:0]          r_mag;
    logic                   r_neg;
    logic [2*COMP_WIDTH-1:0] r_sq;
    logic [MW-1:0]          n_mag;
    logic [2*MW-1:0]        w_sq;

    always_comb begin
        n_mag = i_comp[COMP_WIDTH-1] ? (MW'(0) - {1'b1, i_comp}) : {1'b0, i_comp};
        if (!i_use) begin
            n_mag = '0;
        end
    end

    assign w_sq = r_mag * r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en_in) begin
            r_mag <= n_mag;
            r_neg <= i_use & i_comp[COMP_WIDTH-1];
        end
        r_sq <= w_sq[2*COMP_WIDTH-1:0];
    end

    assign o_square = r_sq;

    // The magnitude waits for the length, which passes the square register, the
    // sum register, MW root stages and the length register in the top level.
    logic [MW-1:0] r_mag_d [MD];
    logic          r_neg_d [MD];
    always_ff @(posedge i_clk) begin
        if (i_div_en) begin
            r_mag_d[0] <= r_mag;
            r_neg_d[0] <= r_neg;
            for (int k = 1; k < MD; k++) begin
                r_mag_d[k] <= r_mag_d[k-1];
                r_neg_d[k] <= r_neg_d[k-1];
            end
        end
    end

    logic [NW-1:0] w_num;
    logic [DW-1:0] w_den;
    assign w_num = NW'({r_mag_d[MD-1], {(UNIT_FRAC_BITS + 1){1'b0}}}) + NW'(i_len);
    assign w_den = {i_len, 1'b0};

    logic [NW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_sg  [QW+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_num;
        r_den[0] <= w_den;
        r_q[0]   <= '0;
        r_sg[0]  <= r_neg_d[MD-1];
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int SH = QW - 1 - s;
        logic [NW+QW-1:0] w_trial;
        logic             w_ok;
        assign w_trial = (NW+QW)'(r_den[s]) << SH;
        assign w_ok    = (NW+QW)'(r_rem[s]) >= w_trial;
        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= w_ok ? NW'((NW+QW)'(r_rem[s]) - w_trial) : r_rem[s];
            r_den[s+1] <= r_den[s];
            r_q[s+1]   <= r_q[s] | (QW'(w_ok) << SH);
            r_sg[s+1]  <= r_sg[s];
        end
    end

    assign o_unit = r_sg[QW] ? (QW'(0) - r_q[QW]) : r_q[QW];

endmodule

[rtl/core/vn_sqrt.sv]
// ============================================================================
// vn_sqrt: pipelined integer square root
// Adds the lane squares, then resolves one root bit per stage.
// ============================================================================
module vn_sqrt
    import vn_pkg::*;
#(
    parameter int COMP_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic [2*COMP_WIDTH-1:0]     i_sq [LANES],
    output logic [COMP_WIDTH:0]         o_root
);

    localparam int SW  = 2*COMP_WIDTH + 2;
    localparam int RW  = COMP_WIDTH + 1;
    localparam int RMW = RW + 3;

    logic [SW-1:0]  r_v  [RW];
    logic [RMW-1:0] r_rm [RW];
    logic [RW-1:0]  r_r  [RW+1];

    always_ff @(posedge i_clk) begin
        r_v[0]  <= SW'(i_sq[0]) + SW'(i_sq[1]) + SW'(i_sq[2]) + SW'(i_sq[3]);
        r_rm[0] <= '0;
        r_r[0]  <= '0;
    end

    // Each stage brings down the next bit pair and tries the digit one.
    for (genvar s = 0; s < RW; s++) begin : g_root
        logic [RMW-1:0] w_cur;
        logic [RMW-1:0] w_trial;
        logic           w_ok;
        assign w_cur   = {r_rm[s][RMW-3:0], r_v[s][SW-1 -: 2]};
        assign w_trial = RMW'({r_r[s], 2'b01});
        assign w_ok    = w_cur >= w_trial;
        always_ff @(posedge i_clk) begin
            r_r[s+1] <= {r_r[s][RW-2:0], w_ok};
        end
        if (s < RW - 1) begin : g_next
            always_ff @(posedge i_clk) begin
                r_v[s+1]  <= r_v[s] << 2;
                r_rm[s+1] <= w_ok ? (w_cur - w_trial) : w_cur;
            end
        end
    end

    assign o_root = r_r[RW];

endmodule

[rtl/core/vector_normalize_core.sv]
// ============================================================================
// vector_normalize_core: 3D/4D vector normalization
// Four lanes square and divide; a shared root unit gives the length.
// One vector is accepted per cycle while o_ready is high. The pipeline
// never stalls; o_ready holds off input while the output FIFO could fill
// up. Reset clears all valid flags and pointers, not the payload.
// ============================================================================
module vector_normalize_core
    import vn_pkg::*;
#(
    parameter int COMP_WIDTH     = 16,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [COMP_WIDTH-1:0]     i_comp_0,
    input  logic signed [COMP_WIDTH-1:0]     i_comp_1,
    input  logic signed [COMP_WIDTH-1:0]     i_comp_2,
    input  logic signed [COMP_WIDTH-1:0]     i_comp_3,
    input  logic                             i_four_wide,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [UNIT_FRAC_BITS+1:0] o_unit_0,
    output logic signed [UNIT_FRAC_BITS+1:0] o_unit_1,
    output logic signed [UNIT_FRAC_BITS+1:0] o_unit_2,
    output logic signed [UNIT_FRAC_BITS+1:0] o_unit_3,
    output logic [COMP_WIDTH:0]              o_magnitude,
    output logic                             o_zero_vector
);

    localparam int RW   = COMP_WIDTH + 1;
    localparam int QW   = UNIT_FRAC_BITS + 2;
    localparam int DEPTH = 2 + 1 + RW + 1 + QW + 1;

    // Free-running pipeline into an output FIFO with a registered head;
    // o_ready admits a transaction only while every one in flight has room.
    logic r_vld [DEPTH];
    logic [RW-1:0] r_len [QW+2];

    logic signed [COMP_WIDTH-1:0] w_comp [LANES];
    logic [2*COMP_WIDTH-1:0]      w_sq [LANES];
    logic signed [QW-1:0]         w_unit [LANES];
    logic [RW-1:0]                w_root;
    logic                         w_acc;

    assign w_comp[0] = i_comp_0;
    assign w_comp[1] = i_comp_1;
    assign w_comp[2] = i_comp_2;
    assign w_comp[3] = i_comp_3;
    assign w_acc = i_valid & o_ready;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        vn_lane #(
            .COMP_WIDTH     (COMP_WIDTH),
            .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en_in  (1'b1),
            .i_comp   (w_comp[l]),
            .i_use    ((l < 3) | i_four_wide),
            .o_square (w_sq[l]),
            .i_len    (r_len[0]),
            .i_div_en (1'b1),
            .o_unit   (w_unit[l])
        );
    end

    vn_sqrt #(.COMP_WIDTH(COMP_WIDTH)) u_sqrt (
        .i_clk  (i_clk),
        .i_sq   (w_sq),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        r_len[0] <= w_root;
        for (int k = 1; k < QW + 2; k++) begin
            r_len[k] <= r_len[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= w_acc;
            for (int k = 1; k < DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Output FIFO.
    localparam int FD = DEPTH + 3;
    localparam int AW = $clog2(FD);
    logic [4*QW+RW-1:0] r_mem [FD];
    logic [4*QW+RW-1:0] r_out;
    logic               r_ov;
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt, r_infl;
    logic          w_push, w_pop, w_load;
    logic [4*QW+RW-1:0] w_entry;

    assign w_push  = r_vld[DEPTH-1];
    assign w_pop   = r_ov & i_ready;
    assign w_load  = (r_cnt != '0) & (!r_ov | i_ready);
    assign o_ready = (r_cnt + r_infl + (AW+1)'(r_ov)) < (AW+1)'(FD);
    assign o_valid = r_ov;
    assign w_entry = (r_len[QW+1] == '0) ? '0
                   : {w_unit[0], w_unit[1], w_unit[2], w_unit[3], r_len[QW+1]};

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_entry;
        end
        if (w_load) begin
            r_out <= r_mem[r_rp];
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_infl <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(FD-1)) ? '0 : r_wp + 1'b1;
            if (w_load) r_rp <= (r_rp == AW'(FD-1)) ? '0 : r_rp + 1'b1;
            r_cnt  <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_load);
            r_infl <= r_infl + (AW+1)'(w_acc) - (AW+1)'(w_push);
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (w_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_unit_0      = r_out[4*QW+RW-1 -: QW];
    assign o_unit_1      = r_out[3*QW+RW-1 -: QW];
    assign o_unit_2      = r_out[2*QW+RW-1 -: QW];
    assign o_unit_3      = r_out[QW+RW-1 -: QW];
    assign o_magnitude   = r_out[RW-1:0];
    assign o_zero_vector = o_valid & (r_out[RW-1:0] == '0);

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(FD)) else $error("fifo overflow");
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt + r_infl + (AW+1)'(r_ov)) <= (AW+1)'(FD)) else $error("credit overrun");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_out))) else $error("output not held");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_zero_vector |-> (o_unit_0 == '0 && o_unit_1 == '0 && o_unit_2 == '0
                           && o_unit_3 == '0)) else $error("zero vector units");

endmodule
